FILE: sv/p1305_pkg.sv
package p1305_pkg;

	localparam int WordW     = 64;
	localparam int BlkW      = 2 * WordW;
	localparam int BlkBytes  = BlkW / 8;
	localparam int CntW      = 5;
	localparam int FullCnt   = 16;
	localparam int LimbW     = 26;
	localparam int NumLimbs  = 5;
	localparam int AccW      = LimbW * NumLimbs;
	localparam int HLimbW    = LimbW + 1;
	localparam int R5W       = LimbW + 3;
	localparam int ProdW     = HLimbW + R5W;
	localparam int ColW      = ProdW + 3;
	localparam int SumW      = ColW + LimbW * (NumLimbs - 1) + 1;
	localparam int FoldMul   = 5;
	localparam int CfgIdxW   = 3;

	localparam logic [WordW-1:0] RClampLo = 64'h0FFF_FFFC_0FFF_FFFF;
	localparam logic [WordW-1:0] RClampHi = 64'h0FFF_FFFC_0FFF_FFFC;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_KEY_R_LOW  = 3'd0,
		CFG_KEY_R_HIGH = 3'd1,
		CFG_KEY_S_LOW  = 3'd2,
		CFG_KEY_S_HIGH = 3'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [BlkW-1:0] r;
		logic [BlkW-1:0] s;
	} key_t;

	// keep the valid bytes and put the pad bit right after them
	function automatic logic [AccW-1:0] pad_block(input logic [BlkW-1:0] blk,
			input logic [CntW-1:0] cnt);
		logic [AccW-1:0] m;
		logic [CntW-1:0] c;
		c = cnt[CntW-1] ? CntW'(FullCnt) : cnt;
		m = '0;
		for (int i = 0; i < BlkBytes; i++) begin
			if (CntW'(i) < c) begin
				m[8*i +: 8] = blk[8*i +: 8];
			end
		end
		m[{c, 3'b000}] = 1'b1;
		return m;
	endfunction

	// (acc + m) * r mod 2^130-5, limb products then three folds at 2^130
	function automatic logic [AccW-1:0] mul_reduce(input logic [AccW-1:0] acc,
			input logic [AccW-1:0] m, input logic [BlkW-1:0] rk);
		logic [NumLimbs-1:0][HLimbW-1:0] h;
		logic [NumLimbs-1:0][LimbW-1:0]  r;
		logic [NumLimbs-1:0][R5W-1:0]    r5;
		logic [NumLimbs-1:0][ColW-1:0]   d;
		logic [AccW-1:0]                 r_ext;
		logic [SumW-1:0]                 t;
		logic [AccW:0]                   f1;
		logic [AccW:0]                   f2;
		logic [AccW:0]                   f3;
		r_ext = AccW'(rk);
		for (int i = 0; i < NumLimbs; i++) begin
			h[i]  = HLimbW'(acc[LimbW*i +: LimbW]) + HLimbW'(m[LimbW*i +: LimbW]);
			r[i]  = r_ext[LimbW*i +: LimbW];
			r5[i] = R5W'(r[i]) * R5W'(FoldMul);
		end
		for (int i = 0; i < NumLimbs; i++) begin
			d[i] = '0;
			for (int j = 0; j < NumLimbs; j++) begin
				if (j <= i) begin
					d[i] = d[i] + ColW'(ProdW'(h[j]) * ProdW'(r[i-j]));
				end else begin
					d[i] = d[i] + ColW'(ProdW'(h[j]) * ProdW'(r5[i+NumLimbs-j]));
				end
			end
		end
		t = '0;
		for (int i = 0; i < NumLimbs; i++) begin
			t = t + (SumW'(d[i]) << (LimbW * i));
		end
		f1 = (AccW+1)'(t[AccW-1:0]) + (AccW+1)'(t[SumW-1:AccW]) * (AccW+1)'(FoldMul);
		f2 = (AccW+1)'(f1[AccW-1:0]) + (AccW+1)'(f1[AccW]) * (AccW+1)'(FoldMul);
		f3 = (AccW+1)'(f2[AccW-1:0]) + (AccW+1)'(f2[AccW]) * (AccW+1)'(FoldMul);
		return f3[AccW-1:0];
	endfunction

	// full reduction below p, then add s mod 2^128
	function automatic logic [BlkW-1:0] final_tag(input logic [AccW-1:0] h,
			input logic [BlkW-1:0] s);
		logic [AccW:0]   g;
		logic [AccW-1:0] hr;
		g  = (AccW+1)'(h) + (AccW+1)'(FoldMul);
		hr = g[AccW] ? g[AccW-1:0] : h;
		return hr[BlkW-1:0] + s;
	endfunction

endpackage

FILE: sv/poly1305_mac.sv
// poly1305 one-time authenticator
// load the 32-byte key on the cfg channel first: index 0/1 take r (clamped here),
// index 2/3 take s, each as a 64-bit little-endian word; writes must go in while
// idle, which the block does not enforce. the in channel takes one 16-byte block
// per beat with its byte count; a count below 16 pads the block after its last
// byte, a count of zero absorbs nothing. last_block ends the message: that beat
// yields one tag beat on the out channel and the accumulator starts again from
// zero for the next message. throughput is one block per cycle unless a last
// block waits on a stalled tag side; accumulate, multiply by r and fold modulo
// 2^130-5 are combinational around the accumulator register. a last block is
// absorbed from the input register into the reduction register; final reduction
// and the add of s then fill the output register. a stalled receiver holds the
// tag in the output register; one more finished tag waits in the reduction
// register and one last block in the input register, after which in_ready drops;
// blocks that are not last keep flowing meanwhile. reset clears the key, the
// accumulator and all valid flags; in_ready is high right after reset.
module poly1305_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [p1305_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [p1305_pkg::WordW-1:0]        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [p1305_pkg::WordW-1:0]        block_low,
	input  logic [p1305_pkg::WordW-1:0]        block_high,
	input  logic [p1305_pkg::CntW-1:0]         byte_count,
	input  logic                               last_block,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [p1305_pkg::WordW-1:0]        tag_low,
	output logic [p1305_pkg::WordW-1:0]        tag_high
);

	p1305_pkg::key_t             key;
	logic                        fin_valid;
	logic                        fin_ready;
	logic [p1305_pkg::AccW-1:0]  fin_h;

	p1305_keys u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key)
	);

	p1305_absorb u_absorb (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.block_low  (block_low),
		.block_high (block_high),
		.byte_count (byte_count),
		.last_block (last_block),
		.key        (key),
		.fin_valid  (fin_valid),
		.fin_ready  (fin_ready),
		.fin_h      (fin_h)
	);

	p1305_tag u_tag (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin_h     (fin_h),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tag_low   (tag_low),
		.tag_high  (tag_high)
	);

endmodule

FILE: sv/p1305_keys.sv
module p1305_keys (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [p1305_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [p1305_pkg::WordW-1:0]        cfg_data,
	output p1305_pkg::key_t                    key
);

	logic [p1305_pkg::WordW-1:0] r_lo_q;
	logic [p1305_pkg::WordW-1:0] r_hi_q;
	logic [p1305_pkg::WordW-1:0] s_lo_q;
	logic [p1305_pkg::WordW-1:0] s_hi_q;

	assign cfg_ready = 1'b1;

	// r is stored already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_lo_q <= '0;
			r_hi_q <= '0;
			s_lo_q <= '0;
			s_hi_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (p1305_pkg::cfg_idx_t'(cfg_index))
				p1305_pkg::CFG_KEY_R_LOW:  r_lo_q <= cfg_data & p1305_pkg::RClampLo;
				p1305_pkg::CFG_KEY_R_HIGH: r_hi_q <= cfg_data & p1305_pkg::RClampHi;
				p1305_pkg::CFG_KEY_S_LOW:  s_lo_q <= cfg_data;
				p1305_pkg::CFG_KEY_S_HIGH: s_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key.r = {r_hi_q, r_lo_q};
	assign key.s = {s_hi_q, s_lo_q};

endmodule

FILE: sv/p1305_absorb.sv
module p1305_absorb (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [p1305_pkg::WordW-1:0]        block_low,
	input  logic [p1305_pkg::WordW-1:0]        block_high,
	input  logic [p1305_pkg::CntW-1:0]         byte_count,
	input  logic                               last_block,
	input  p1305_pkg::key_t                    key,
	output logic                               fin_valid,
	input  logic                               fin_ready,
	output logic [p1305_pkg::AccW-1:0]         fin_h
);

	logic                        s1_valid_q;
	logic [p1305_pkg::BlkW-1:0]  blk_s1;
	logic [p1305_pkg::CntW-1:0]  cnt_s1;
	logic                        last_s1;
	logic [p1305_pkg::AccW-1:0]  acc_q;
	logic [p1305_pkg::AccW-1:0]  m;
	logic [p1305_pkg::AccW-1:0]  prod;
	logic [p1305_pkg::AccW-1:0]  acc_next;
	logic                        s1_adv;
	logic                        in_acc;

	assign m        = p1305_pkg::pad_block(blk_s1, cnt_s1);
	assign prod     = p1305_pkg::mul_reduce(acc_q, m, key.r);
	assign acc_next = (cnt_s1 == '0) ? acc_q : prod;

	// a block that is not last never waits on the tag side
	assign s1_adv    = s1_valid_q && (!last_s1 || fin_ready);
	assign in_ready  = !s1_valid_q || s1_adv;
	assign in_acc    = in_valid && in_ready;
	assign fin_valid = s1_valid_q && last_s1;
	assign fin_h     = acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			acc_q      <= '0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				acc_q <= last_s1 ? '0 : acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			blk_s1  <= {block_high, block_low};
			cnt_s1  <= byte_count;
			last_s1 <= last_block;
		end
	end

endmodule

FILE: sv/p1305_tag.sv
module p1305_tag (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               fin_valid,
	output logic                               fin_ready,
	input  logic [p1305_pkg::AccW-1:0]         fin_h,
	input  p1305_pkg::key_t                    key,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [p1305_pkg::WordW-1:0]        tag_low,
	output logic [p1305_pkg::WordW-1:0]        tag_high
);

	logic                        s2_valid_q;
	logic [p1305_pkg::AccW-1:0]  h_s2;
	logic                        out_valid_q;
	logic [p1305_pkg::BlkW-1:0]  tag_q;
	logic [p1305_pkg::BlkW-1:0]  tag_d;
	logic                        s2_adv;

	assign tag_d     = p1305_pkg::final_tag(h_s2, key.s);
	assign s2_adv    = s2_valid_q && (!out_valid_q || out_ready);
	assign fin_ready = !s2_valid_q || s2_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_valid && fin_ready) begin
				s2_valid_q <= 1'b1;
			end else if (s2_adv) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid && fin_ready) begin
			h_s2 <= fin_h;
		end
		if (s2_adv) begin
			tag_q <= tag_d;
		end
	end

	assign out_valid = out_valid_q;
	assign tag_low   = tag_q[p1305_pkg::WordW-1:0];
	assign tag_high  = tag_q[p1305_pkg::BlkW-1:p1305_pkg::WordW];

endmodule

FILE: sv/p1305_chk.sv
module p1305_chk (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               last_block,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [p1305_pkg::WordW-1:0]        tag_low,
	input  logic [p1305_pkg::WordW-1:0]        tag_high
);

	// tags owed: last blocks taken minus tag beats delivered
	logic [2:0] pend_q;
	logic       last_acc;
	logic       out_acc;

	assign last_acc = in_valid && in_ready && last_block;
	assign out_acc  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(last_acc) - 3'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tag_low) && $stable(tag_high))
		else $error("tag changed or dropped while stalled");

	a_body_flows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last_block |=> in_ready)
		else $error("input stalled after a non-final block");

	a_no_stray_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("tag beat without a pending final block");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("more final blocks held than the pipeline can store");

endmodule

bind poly1305_mac p1305_chk u_chk (.*);
